// ----- rtl/rfe_pkg.sv -----
`timescale 1ns / 1ps

package rfe_pkg;

  localparam int SLOT_W   = 6;
  localparam int COORD_W  = 6;
  localparam int DATA_W   = 32;
  localparam int MOD_W    = 3;

  localparam int OPERAND_SLOTS_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FACTOR = 1'b1;

  localparam int MOD_COMPL_BIT   = 0;
  localparam int MOD_RECIP_BIT   = 1;
  localparam int MOD_NEWPROD_BIT = 2;

  localparam logic [DATA_W-1:0] FX_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] FX_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_EMIT
  } rfe_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_res_t;

  function automatic logic signed [63:0] sext64(input logic [DATA_W-1:0] v);
    return {{(64-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // clamp a wide signed value to the 32-bit range
  function automatic sat_res_t sat_fx(input logic signed [63:0] v);
    sat_res_t r;
    if (v > sext64(FX_MAX)) begin
      r.val = FX_MAX;
      r.ovf = 1'b1;
    end else if (v < sext64(FX_MIN)) begin
      r.val = FX_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rfe_if.sv -----
`timescale 1ns / 1ps

interface rfe_in_if import rfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [SLOT_W-1:0]  slot;
  logic [DATA_W-1:0]  load_value;
  logic [MOD_W-1:0]   modifier_bits;
  logic               last_factor;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (
    output valid, action, slot, load_value, modifier_bits, last_factor, row, col,
    input  ready
  );
  modport sink (
    input  valid, action, slot, load_value, modifier_bits, last_factor, row, col,
    output ready
  );
endinterface

interface rfe_out_if import rfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [DATA_W-1:0]  rate_value;
  logic               overflow;

  modport source (
    output valid, out_row, out_col, rate_value, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, rate_value, overflow,
    output ready
  );
endinterface

// ----- rtl/rfe_div.sv -----
`timescale 1ns / 1ps

// restoring divider for 2^(2*FRAC_BITS) / divisor, one quotient bit a cycle
module rfe_div import rfe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DATA_W-1:0]          divisor,
  output logic                       done,
  output logic [2*FRAC_BITS:0]       quotient
);

  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [QW-1:0]    dvd_r;
  logic [QW-1:0]    quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dsr_r;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, dvd_r[QW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
    fits   = !diff[DATA_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
        dvd_r  <= {1'b1, {(QW-1){1'b0}}};
        quo_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[QW-2:0], 1'b0};
        quo_r <= {quo_r[QW-2:0], fits};
        rem_r <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/rate_formula_evaluator.sv -----
`timescale 1ns / 1ps

// channel  | port    | direction | payload
// ---------+---------+-----------+-------------------------------------------------
// input    | in_ch   | sink      | action, slot, load_value, modifier_bits,
//          |         |           | last_factor, row, col
// result   | out_ch  | source    | out_row, out_col, rate_value, overflow
//
// a load request completes in ST_IDLE; a factor request steps through ST_FETCH, ST_MUL
// and ST_SCALE, then ST_EMIT when it is the last factor, and ST_DIV before ST_MUL when
// it needs a Q16.16 reciprocal, formed by the bit-serial divider one quotient bit a cycle
// operands live in a single-port synchronous store with a registered read
// reset clears the element accumulators and the control; the operand store is not cleared
// a waiting result sits in the output register; only the final factor of the next
// element stalls behind it

module rate_formula_evaluator import rfe_pkg::*; #(
  parameter int OPERAND_SLOTS = OPERAND_SLOTS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rfe_in_if.sink    in_ch,
  rfe_out_if.source out_ch
);

  localparam int AW = $clog2(OPERAND_SLOTS);
  localparam int CW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

  rfe_state_t state_r, state_nxt;

  logic [DATA_W-1:0] operand_mem [OPERAND_SLOTS];
  logic [DATA_W-1:0] rd_data_r;

  logic [CW-1:0] slot_ext;
  logic [AW-1:0] addr;
  logic          slot_ok;
  logic          in_ready;
  logic          in_acc;
  logic          mem_we;
  logic          mem_re;
  logic          div_start;
  logic          div_done;
  logic          emit_ok;
  logic [QW-1:0] div_quo;

  logic [MOD_W-1:0]   mod_r, mod_nxt;
  logic               last_r, last_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic               slot_ok_r, slot_ok_nxt;
  logic               neg_r, neg_nxt;
  logic [DATA_W-1:0]  x_r, x_nxt;
  logic [DATA_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0]  prod_r, prod_nxt;
  logic               ovf_r, ovf_nxt;
  logic signed [63:0] prod64_r, prod64_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_row_r, out_row_nxt;
  logic [COORD_W-1:0] out_col_r, out_col_nxt;
  logic [DATA_W-1:0]  out_rate_r, out_rate_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [DATA_W-1:0] x_fetch;
  logic [DATA_W-1:0] div_dsr;
  logic              use_compl;
  logic              use_recip;
  logic              use_newprod;
  sat_res_t          acc_s;
  sat_res_t          compl_s;
  sat_res_t          quo_s;
  sat_res_t          scale_s;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;

  assign slot_ext = CW'(in_ch.slot);
  assign addr     = slot_ext[AW-1:0];
  assign slot_ok  = slot_ext < CW'(OPERAND_SLOTS);

  always_comb begin
    x_fetch     = slot_ok_r ? rd_data_r : '0;
    div_dsr     = x_fetch[DATA_W-1] ? (~x_fetch + DATA_W'(1)) : x_fetch;
    use_compl   = mod_r[MOD_COMPL_BIT];
    use_recip   = !mod_r[MOD_COMPL_BIT] && mod_r[MOD_RECIP_BIT];
    use_newprod = mod_r[MOD_NEWPROD_BIT];
    acc_s       = sat_fx(sext64(sum_r) + sext64(prod_r));
    compl_s     = sat_fx(sext64(FX_ONE) - sext64(x_fetch));
    quo_s       = neg_r ? sat_fx(-$signed(64'(div_quo))) : sat_fx($signed(64'(div_quo)));
    scale_s     = sat_fx(prod64_r >>> FRAC_BITS);
    mul_a       = prod_r;
    mul_b       = x_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.action == ACT_FACTOR) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (use_recip && x_fetch != '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    emit_ok   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_FETCH: div_start = use_recip && x_fetch != '0;
      ST_EMIT:  emit_ok   = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_acc = in_ch.valid && in_ready;
  assign mem_we = in_acc && in_ch.action == ACT_LOAD && slot_ok;
  assign mem_re = in_acc && in_ch.action == ACT_FACTOR;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      operand_mem[addr] <= in_ch.load_value;
    end
    if (mem_re) begin
      rd_data_r <= operand_mem[addr];
    end
  end

  rfe_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // datapath
  always_comb begin
    mod_nxt      = mod_r;
    last_nxt     = last_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    slot_ok_nxt  = slot_ok_r;
    neg_nxt      = neg_r;
    x_nxt        = x_r;
    sum_nxt      = sum_r;
    prod_nxt     = prod_r;
    ovf_nxt      = ovf_r;
    prod64_nxt   = prod64_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_rate_nxt = out_rate_r;
    out_ovf_nxt  = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (mem_re) begin
          mod_nxt     = in_ch.modifier_bits;
          last_nxt    = in_ch.last_factor;
          row_nxt     = in_ch.row;
          col_nxt     = in_ch.col;
          slot_ok_nxt = slot_ok;
        end
      end
      ST_FETCH: begin
        if (use_newprod) begin
          sum_nxt  = acc_s.val;
          prod_nxt = FX_ONE;
        end
        neg_nxt = x_fetch[DATA_W-1];
        if (use_compl) begin
          x_nxt = compl_s.val;
        end else if (use_recip) begin
          // reciprocal of zero pins to the largest value
          x_nxt = FX_MAX;
        end else begin
          x_nxt = x_fetch;
        end
        ovf_nxt = ovf_r | (use_newprod & acc_s.ovf) | (use_compl & compl_s.ovf)
                | (use_recip && x_fetch == '0);
      end
      ST_DIV: begin
        if (div_done) begin
          x_nxt   = quo_s.val;
          ovf_nxt = ovf_r | quo_s.ovf;
        end
      end
      ST_MUL: begin
        prod64_nxt = mul_a * mul_b;
      end
      ST_SCALE: begin
        prod_nxt = scale_s.val;
        ovf_nxt  = ovf_r | scale_s.ovf;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_rate_nxt  = acc_s.val;
          out_ovf_nxt   = ovf_r | acc_s.ovf;
          sum_nxt       = '0;
          prod_nxt      = FX_ONE;
          ovf_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      prod_r      <= FX_ONE;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      prod_r      <= prod_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_r      <= mod_nxt;
    last_r     <= last_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    slot_ok_r  <= slot_ok_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    prod64_r   <= prod64_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_rate_r <= out_rate_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.rate_value = out_rate_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

// ----- bench/rfe_result_checker.sv -----
`timescale 1ns / 1ps

module rfe_result_checker import rfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rfe_in_if    in_mon,
  rfe_out_if   out_mon,
  output int   mismatch_count,
  output int   results_left
);

  localparam int    FRAC    = FRAC_BITS_DEF;
  localparam longint FX_ONE  = longint'(1) << FRAC;
  localparam longint FX_HI   = 64'sd2147483647;
  localparam longint FX_LO   = -64'sd2147483648;
  localparam longint RECIP_N = longint'(1) << (2 * FRAC);

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  rate;
    logic               ovf;
  } rate_element_t;

  rate_element_t             pending_elements[$];
  logic signed [DATA_W-1:0]  operand_mem [OPERAND_SLOTS_DEF];
  logic signed [DATA_W-1:0]  sum_acc;
  logic signed [DATA_W-1:0]  prod_acc;
  logic                      elem_ovf;

  function automatic logic signed [DATA_W-1:0] clamp_fx(input longint v, inout logic ovf);
    if (v > FX_HI) begin
      ovf = 1'b1;
      return FX_HI[DATA_W-1:0];
    end
    if (v < FX_LO) begin
      ovf = 1'b1;
      return FX_LO[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic void clear_element();
    sum_acc  = '0;
    prod_acc = FX_ONE[DATA_W-1:0];
    elem_ovf = 1'b0;
  endfunction

  // apply one accepted request: a load writes the model store, a factor advances the accumulators
  function automatic void evaluate_request(
    input logic               act,
    input logic [SLOT_W-1:0]  slot,
    input logic [DATA_W-1:0]  value,
    input logic [MOD_W-1:0]   mods,
    input logic               last,
    input logic [COORD_W-1:0] row,
    input logic [COORD_W-1:0] col
  );
    longint        x;
    rate_element_t e;
    if (act == ACT_LOAD) begin
      operand_mem[slot] = value;
      return;
    end
    x = operand_mem[slot];
    if (mods[MOD_NEWPROD_BIT]) begin
      sum_acc  = clamp_fx(longint'(sum_acc) + longint'(prod_acc), elem_ovf);
      prod_acc = FX_ONE[DATA_W-1:0];
    end
    // complement wins over reciprocal when both bits are set
    if (mods[MOD_COMPL_BIT]) begin
      x = clamp_fx(FX_ONE - x, elem_ovf);
    end else if (mods[MOD_RECIP_BIT]) begin
      if (x == 0) begin
        elem_ovf = 1'b1;
        x = FX_HI;
      end else begin
        x = clamp_fx(RECIP_N / x, elem_ovf);
      end
    end
    prod_acc = clamp_fx((longint'(prod_acc) * x) >>> FRAC, elem_ovf);
    if (!last) return;
    e.row  = row;
    e.col  = col;
    e.rate = clamp_fx(longint'(sum_acc) + longint'(prod_acc), elem_ovf);
    e.ovf  = elem_ovf;
    pending_elements.push_back(e);
    clear_element();
  endfunction

  function automatic void compare_element(
    input logic [COORD_W-1:0] row,
    input logic [COORD_W-1:0] col,
    input logic [DATA_W-1:0]  rate,
    input logic               ovf
  );
    rate_element_t e;
    if (pending_elements.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected element: row %0d col %0d value %h ovf %b", row, col, rate, ovf);
      return;
    end
    e = pending_elements.pop_front();
    if (e.row !== row || e.col !== col || e.rate !== rate || e.ovf !== ovf) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("element mismatch: expected row %0d col %0d value %h ovf %b, got %0d %0d %h %b",
                 e.row, e.col, e.rate, e.ovf, row, col, rate, ovf);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_element();
    end else begin
      if (in_mon.valid && in_mon.ready)
        evaluate_request(in_mon.action, in_mon.slot, in_mon.load_value, in_mon.modifier_bits,
                         in_mon.last_factor, in_mon.row, in_mon.col);
      if (out_mon.valid && out_mon.ready)
        compare_element(out_mon.out_row, out_mon.out_col, out_mon.rate_value, out_mon.overflow);
    end
    results_left <= pending_elements.size();
  end

endmodule

// ----- bench/tb_rate_formula_evaluator.sv -----
`timescale 1ns / 1ps

module tb_rate_formula_evaluator import rfe_pkg::*;;

  localparam logic [MOD_W-1:0] MOD_PLAIN   = 3'b000;
  localparam logic [MOD_W-1:0] MOD_COMPL   = 3'b001;
  localparam logic [MOD_W-1:0] MOD_RECIP   = 3'b010;
  localparam logic [MOD_W-1:0] MOD_NEWPROD = 3'b100;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 60;

  logic clk;
  logic rst_n;

  rfe_in_if  in_ch ();
  rfe_out_if out_ch ();

  int mismatch_count;
  int results_left;
  int requests_sent;
  int stall_cycles;
  bit steady_flow;
  bit slot_loaded [64];
  int loaded_slots[$];

  rate_formula_evaluator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rfe_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .results_left   (results_left)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit take_break();
    return !steady_flow && ($urandom_range(0, 99) < 9);
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= !take_break();
  end

  // no request moving for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** rate_formula_evaluator: FAILED **");
      $finish;
    end
  end

  task automatic issue_request(
    input logic               act,
    input logic [SLOT_W-1:0]  slot,
    input logic [DATA_W-1:0]  value,
    input logic [MOD_W-1:0]   mods,
    input logic               last,
    input logic [COORD_W-1:0] row,
    input logic [COORD_W-1:0] col
  );
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.slot          <= slot;
    in_ch.load_value    <= value;
    in_ch.modifier_bits <= mods;
    in_ch.last_factor   <= last;
    in_ch.row           <= row;
    in_ch.col           <= col;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // load requests carry random junk in the fields the block ignores
  task automatic load_operand(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] value);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
    issue_request(ACT_LOAD, slot, value, MOD_W'($urandom), 1'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic apply_factor(
    input logic [SLOT_W-1:0]  slot,
    input logic [MOD_W-1:0]   mods,
    input logic               last,
    input logic [COORD_W-1:0] row,
    input logic [COORD_W-1:0] col
  );
    issue_request(ACT_FACTOR, slot, DATA_W'($urandom), mods, last, row, col);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = FX_MAX;
          2: v = FX_MIN;
          3: v = -1;
          default: v = 32'h0001_0000;
        endcase
      end
      2, 3, 4, 5: v = int'($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
      default: begin
        v = $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // only slots written since reset may be read
  function automatic logic [SLOT_W-1:0] pick_loaded_slot();
    return SLOT_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
  endfunction

  initial begin
    int n;
    rst_n               <= 1'b0;
    steady_flow         = 1'b0;
    requests_sent       = 0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_LOAD;
    in_ch.slot          <= '0;
    in_ch.load_value    <= '0;
    in_ch.modifier_bits <= MOD_PLAIN;
    in_ch.last_factor   <= 1'b0;
    in_ch.row           <= '0;
    in_ch.col           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_operand(0, 32'h0000_0000);
    load_operand(1, 32'h0001_0000);
    load_operand(2, FX_MAX);
    load_operand(3, FX_MIN);
    load_operand(4, 32'hFFFF_FFFF);
    load_operand(5, 32'h0000_8000);
    load_operand(63, 32'hFFFE_0000);

    apply_factor(5, MOD_PLAIN, 1'b1, 0, 0);
    // reciprocal of zero
    apply_factor(0, MOD_RECIP, 1'b1, 63, 63);
    apply_factor(3, MOD_COMPL, 1'b1, 1, 62);
    apply_factor(2, MOD_PLAIN, 1'b0, 2, 2);
    apply_factor(2, MOD_PLAIN, 1'b1, 21, 42);
    apply_factor(4, MOD_RECIP, 1'b1, 42, 21);
    apply_factor(63, MOD_COMPL | MOD_RECIP, 1'b1, 7, 56);
    apply_factor(5, MOD_PLAIN, 1'b0, 0, 0);
    apply_factor(63, MOD_NEWPROD | MOD_RECIP, 1'b0, 0, 0);
    apply_factor(1, MOD_NEWPROD | MOD_COMPL | MOD_RECIP, 1'b1, 56, 7);
    apply_factor(1, MOD_NEWPROD, 1'b0, 0, 0);
    apply_factor(2, MOD_NEWPROD, 1'b0, 0, 0);
    apply_factor(2, MOD_NEWPROD, 1'b1, 62, 1);
    apply_factor(3, MOD_PLAIN, 1'b0, 0, 0);
    apply_factor(3, MOD_PLAIN, 1'b1, 13, 50);

    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      steady_flow = requests_sent >= 600 && requests_sent < 850;
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 3)) load_operand(SLOT_W'($urandom), pick_operand());
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          apply_factor(pick_loaded_slot(), MOD_W'($urandom), k == n - 1,
                       COORD_W'($urandom), COORD_W'($urandom));
      end
    end
    steady_flow = 1'b0;
    in_ch.valid <= 1'b0;

    while (results_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_left == 0)
      $display("** rate_formula_evaluator: PASSED **");
    else
      $display("** rate_formula_evaluator: FAILED **");
    $finish;
  end

endmodule
